[design/scta_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode translator package
// Shared constants, the set-1 key map and the controller command bundle.
// ----------------------------------------------------------------------------
package scta_pkg;

	localparam int FIFO_DEPTH_DEF = 256;
	localparam int CHAR_W         = 7;
	localparam int SCAN_W         = 8;

	// Set-1 make codes of the modifier keys.
	localparam logic [6:0] SC_LSHIFT = 7'h2A;
	localparam logic [6:0] SC_RSHIFT = 7'h36;
	localparam logic [6:0] SC_CTRL   = 7'h1D;

	localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 7'h7A;
	localparam logic [CHAR_W-1:0] CH_CASE    = 7'h20;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // register the incoming request
		logic execute;   // update modifiers, indices and the character store
		logic load;      // move the finished result into the output register
	} scta_cmd_t;

	// Unshifted ASCII code of a make code; zero for keys that produce nothing.
	function automatic logic [CHAR_W-1:0] key_map(input logic [6:0] code);
		logic [CHAR_W-1:0] ch;
		unique case (code)
			7'h01: ch = 7'h1B;
			7'h02: ch = 7'h31;
			7'h03: ch = 7'h32;
			7'h04: ch = 7'h33;
			7'h05: ch = 7'h34;
			7'h06: ch = 7'h35;
			7'h07: ch = 7'h36;
			7'h08: ch = 7'h37;
			7'h09: ch = 7'h38;
			7'h0A: ch = 7'h39;
			7'h0B: ch = 7'h30;
			7'h0C: ch = 7'h2D;
			7'h0D: ch = 7'h3D;
			7'h0E: ch = 7'h08;
			7'h0F: ch = 7'h09;
			7'h10: ch = 7'h71;
			7'h11: ch = 7'h77;
			7'h12: ch = 7'h65;
			7'h13: ch = 7'h72;
			7'h14: ch = 7'h74;
			7'h15: ch = 7'h79;
			7'h16: ch = 7'h75;
			7'h17: ch = 7'h69;
			7'h18: ch = 7'h6F;
			7'h19: ch = 7'h70;
			7'h1A: ch = 7'h5B;
			7'h1B: ch = 7'h5D;
			7'h1C: ch = 7'h0A;
			7'h1E: ch = 7'h61;
			7'h1F: ch = 7'h73;
			7'h20: ch = 7'h64;
			7'h21: ch = 7'h66;
			7'h22: ch = 7'h67;
			7'h23: ch = 7'h68;
			7'h24: ch = 7'h6A;
			7'h25: ch = 7'h6B;
			7'h26: ch = 7'h6C;
			7'h27: ch = 7'h3B;
			7'h28: ch = 7'h27;
			7'h29: ch = 7'h60;
			7'h2B: ch = 7'h5C;
			7'h2C: ch = 7'h7A;
			7'h2D: ch = 7'h78;
			7'h2E: ch = 7'h63;
			7'h2F: ch = 7'h76;
			7'h30: ch = 7'h62;
			7'h31: ch = 7'h6E;
			7'h32: ch = 7'h6D;
			7'h33: ch = 7'h2C;
			7'h34: ch = 7'h2E;
			7'h35: ch = 7'h2F;
			7'h37: ch = 7'h2A;
			7'h39: ch = 7'h20;
			7'h47: ch = 7'h37;
			7'h48: ch = 7'h38;
			7'h49: ch = 7'h39;
			7'h4A: ch = 7'h2D;
			7'h4B: ch = 7'h34;
			7'h4C: ch = 7'h35;
			7'h4D: ch = 7'h36;
			7'h4E: ch = 7'h2B;
			7'h4F: ch = 7'h31;
			7'h50: ch = 7'h32;
			7'h51: ch = 7'h33;
			7'h52: ch = 7'h30;
			7'h53: ch = 7'h2E;
			default: ch = '0;
		endcase
		return ch;
	endfunction

endpackage

[design/scta_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode translator controller
// Sequences capture, execute and result load, and owns the result valid flag.
// ----------------------------------------------------------------------------
module scta_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output scta_pkg::scta_cmd_t cmd
);
	import scta_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_LOAD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	// The output register can take a new result when empty or being drained.
	assign out_free     = !out_valid_q || !result_stall;

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.execute = 1'b1;
				state_nxt   = S_LOAD;
			end
			S_LOAD: begin
				if (out_free) begin
					cmd.load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/scta_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode translator datapath
// Modifier flags, ring FIFO indices and store, and the result register.
// ----------------------------------------------------------------------------
module scta_datapath #(
	parameter int FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  scta_pkg::scta_cmd_t          cmd,
	input  logic                         req_type,
	input  logic [scta_pkg::SCAN_W-1:0]  scan_code,
	output logic [scta_pkg::CHAR_W-1:0]  read_char,
	output logic                         char_available,
	output logic                         shift_held,
	output logic                         ctrl_held,
	output logic                         code_dropped
);
	import scta_pkg::*;

	localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FIFO_DEPTH - 1);

	logic [CHAR_W-1:0] store_q [FIFO_DEPTH];

	logic              req_q;
	logic [SCAN_W-1:0] sc_q;
	logic [IDX_W-1:0]  rd_idx_q;
	logic [IDX_W-1:0]  wr_idx_q;
	logic              shift_q;
	logic              ctrl_q;
	logic              pop_q;
	logic              drop_q;
	logic [CHAR_W-1:0] rdata_q;

	logic [CHAR_W-1:0] read_char_q;
	logic              avail_q;
	logic              shift_out_q;
	logic              ctrl_out_q;
	logic              drop_out_q;

	logic [6:0]        key;
	logic [CHAR_W-1:0] map_ch;
	logic [CHAR_W-1:0] wr_ch;
	logic [IDX_W-1:0]  rd_next;
	logic [IDX_W-1:0]  wr_next;
	logic              fifo_empty;
	logic              fifo_full;
	logic              is_press;
	logic              do_pop;
	logic              do_push;
	logic              do_drop;

	assign key        = sc_q[6:0];
	assign map_ch     = key_map(key);
	assign rd_next    = (rd_idx_q == IDX_LAST) ? '0 : rd_idx_q + 1'b1;
	assign wr_next    = (wr_idx_q == IDX_LAST) ? '0 : wr_idx_q + 1'b1;
	assign fifo_empty = (rd_idx_q == wr_idx_q);
	assign fifo_full  = (wr_next == rd_idx_q);
	assign is_press   = !req_q && !sc_q[7];

	// Letters go uppercase while shift is held; modifiers never map to a code.
	assign wr_ch = (shift_q && map_ch >= CH_LOWER_A && map_ch <= CH_LOWER_Z) ?
		map_ch - CH_CASE : map_ch;

	assign do_pop  = cmd.execute && req_q && !fifo_empty;
	assign do_push = cmd.execute && is_press && (map_ch != '0) && !fifo_full;
	assign do_drop = cmd.execute && is_press && (map_ch != '0) && fifo_full;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			sc_q  <= scan_code;
		end
		if (do_push) begin
			store_q[wr_idx_q] <= wr_ch;
		end
		if (do_pop) begin
			rdata_q <= store_q[rd_idx_q];
		end
		if (cmd.load) begin
			read_char_q <= pop_q ? rdata_q : '0;
			avail_q     <= !fifo_empty;
			shift_out_q <= shift_q;
			ctrl_out_q  <= ctrl_q;
			drop_out_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			pop_q    <= 1'b0;
			drop_q   <= 1'b0;
		end else begin
			if (cmd.execute) begin
				pop_q  <= do_pop;
				drop_q <= do_drop;
				if (!req_q) begin
					if (key == SC_LSHIFT || key == SC_RSHIFT) begin
						shift_q <= !sc_q[7];
					end
					if (key == SC_CTRL) begin
						ctrl_q <= !sc_q[7];
					end
				end
			end
			if (do_pop) begin
				rd_idx_q <= rd_next;
			end
			if (do_push) begin
				wr_idx_q <= wr_next;
			end
		end
	end

	assign read_char      = read_char_q;
	assign char_available = avail_q;
	assign shift_held     = shift_out_q;
	assign ctrl_held      = ctrl_out_q;
	assign code_dropped   = drop_out_q;

endmodule

[design/scancode_to_ascii_fifo_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode-set-1 to ASCII translator with character FIFO
// Top level joining the sequencing controller and the translation datapath.
// ----------------------------------------------------------------------------
// Each transfer on the item side is either a keyboard scancode byte
// (req_type = 0) or a host read (req_type = 1), and each one yields exactly one
// result transfer. Presses of shift and ctrl set their modifier, releases clear
// it; a press that maps to a character queues it (uppercase for letters while
// shift is held) into a ring FIFO of FIFO_DEPTH entries that holds at most
// FIFO_DEPTH-1 characters. A press that finds the FIFO full is discarded and
// reported through code_dropped. A read returns the oldest character, or zero
// when the FIFO is empty. An item passes through the controller states in
// order: its transfer is captured in S_IDLE, S_EXEC performs the single store
// access and state update, and S_LOAD moves the registered store read data
// into the output register once it is free, and the result is offered.
// The controller handles one item at a time, so no new item is taken until the
// previous one is loaded. The result sits in its own output register, so a new
// item is taken while the previous result is still waiting; only the load of
// the following result waits for it.
// The character store needs no clearing after reset: only written entries are
// ever read.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_top #(
	parameter int FIFO_DEPTH = scta_pkg::FIFO_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         req_type,
	input  logic [scta_pkg::SCAN_W-1:0]  scan_code,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [scta_pkg::CHAR_W-1:0]  read_char,
	output logic                         char_available,
	output logic                         shift_held,
	output logic                         ctrl_held,
	output logic                         code_dropped
);
	import scta_pkg::*;

	// Command bundle from the sequencer to the datapath.
	scta_cmd_t cmd;

	scta_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	scta_datapath #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.req_type       (req_type),
		.scan_code      (scan_code),
		.read_char      (read_char),
		.char_available (char_available),
		.shift_held     (shift_held),
		.ctrl_held      (ctrl_held),
		.code_dropped   (code_dropped)
	);

endmodule

[design/scta_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scancode translator port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module scta_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         result_valid,
	input logic                         result_stall,
	input logic [scta_pkg::CHAR_W-1:0]  read_char,
	input logic                         char_available,
	input logic                         code_dropped
);
	import scta_pkg::*;

	// A stalled result stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its character.
	a_char_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(read_char))
		else $error("read_char changed while stalled");

	// A drop only happens on a full FIFO, which is never empty afterwards.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && code_dropped |-> char_available)
		else $error("drop reported with an empty FIFO");

	// A popped character comes from a read, which never drops a code.
	a_pop_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (read_char != '0) |-> !code_dropped)
		else $error("drop reported on a read");

endmodule

bind scancode_to_ascii_fifo_top scta_checker u_scta_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.read_char      (read_char),
	.char_available (char_available),
	.code_dropped   (code_dropped)
);
